@@ src/mma_pkg.sv @@
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the multichannel moving-average unit.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Fixed field widths.
  localparam int CHAN_W     = 4;
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 40;
  localparam int WLEN_W     = 9;
  localparam int CHAN_IDX_W = 6;   // folded channel index, enough for 64 channels
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = 6;

  // Input mode codes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // Configuration register map.
  localparam int          PADDR_W         = 2;
  localparam logic [1:0]  ADDR_WINDOW_LEN = 2'h0;
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 9'd256;

  // Saturation limits of the 32-bit result.
  localparam logic [SUM_W-1:0]  MAG_POS_LIMIT = 40'h00_7FFF_FFFF;
  localparam logic [SUM_W-1:0]  MAG_NEG_LIMIT = 40'h00_8000_0000;
  localparam logic [DATA_W-1:0] AVG_MAX       = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] AVG_MIN       = 32'h8000_0000;

  typedef struct packed {
    logic                     mode;
    logic [CHAN_W-1:0]        channel;
    logic signed [DATA_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]        channel_res;
    logic signed [DATA_W-1:0] average;
    logic                     valid_res;
  } out_word_t;

  typedef enum logic {
    OP_SAMPLE,
    OP_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                  op;
    logic [CHAN_W-1:0]        chan_in;
    logic [CHAN_IDX_W-1:0]    chan_idx;
    logic signed [DATA_W-1:0] sample;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_SAT,
    ST_PUSH
  } eng_state_t;

endpackage

@@ src/mma_fifo.sv @@
// ----------------------------------------------------------------------------
// mma_fifo
// Two-entry first-in first-out queue for one word type.
// ----------------------------------------------------------------------------
module mma_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  T     wdata,
  input  logic pop,
  output logic empty,
  output T     rdata
);

  T           mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ src/mma_front.sv @@
// ----------------------------------------------------------------------------
// mma_front
// Accepts input words, classifies them and queues commands for the engine.
// ----------------------------------------------------------------------------
module mma_front import mma_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_word_t item,
  input  logic     cmd_pop,
  output logic     cmd_empty,
  output cmd_t     cmd
);

  localparam int NUM_CODES = 1 << CHAN_W;

  logic [CHAN_IDX_W-1:0] fold_tbl [NUM_CODES];
  cmd_t                  cmd_in;

  // Channel codes beyond the configured count fold back modulo CHANNELS.
  for (genvar i = 0; i < NUM_CODES; i++) begin : g_fold
    assign fold_tbl[i] = CHAN_IDX_W'(i % CHANNELS);
  end

  always_comb begin
    cmd_in.op       = (item.mode == MODE_CLEAR) ? OP_CLEAR : OP_SAMPLE;
    cmd_in.chan_in  = item.channel;
    cmd_in.chan_idx = fold_tbl[item.channel];
    cmd_in.sample   = item.sample;
  end

  mma_fifo #(
    .T (cmd_t)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd)
  );

endmodule

@@ src/mma_engine.sv @@
// ----------------------------------------------------------------------------
// mma_engine
// Back end: ring history, running sums and a bit-serial divider.
// ----------------------------------------------------------------------------
module mma_engine import mma_pkg::*; #(
  parameter int CHANNELS   = 16,
  parameter int WINDOW_MAX = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WLEN_W-1:0] window_length,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output out_word_t         res
);

  localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW        = $clog2(WINDOW_MAX + 1);
  localparam int XW        = SW + 1;
  localparam int MCW       = $clog2(XW + 1);
  localparam int AW        = CW + SW;
  localparam int MEM_DEPTH = CHANNELS << SW;

  eng_state_t state, state_next;

  // Per-channel state.
  logic [LW-1:0]    fill_cnt [CHANNELS];
  logic [SW-1:0]    oldest   [CHANNELS];
  logic [SUM_W-1:0] wsum     [CHANNELS];

  // History ring memory.
  logic [DATA_W-1:0] hist [MEM_DEPTH];
  logic [DATA_W-1:0] hist_rd;

  // Work registers of the item in progress.
  logic [CW-1:0]     cidx;
  logic [CHAN_W-1:0] chan_in;
  logic [DATA_W-1:0] smp;
  logic              is_full;
  logic [LW-1:0]     fill_l;
  logic [LW-1:0]     len_l;
  logic [SUM_W-1:0]  sum_l;
  logic [XW-1:0]     mod_x;
  logic [LW-1:0]     mod_rem;
  logic [MCW-1:0]    mod_cnt;
  logic [SUM_W-1:0]  dq;
  logic [LW-1:0]     drem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic              neg;
  logic [DATA_W-1:0] res_avg;
  logic              res_valid;

  // Combinational helpers.
  logic [CW-1:0]    ci_new;
  logic [10:0]      wl_wide;
  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    fill_cur;
  logic [SW-1:0]    oldest_cur;
  logic [LW:0]      mod_sh;
  logic [SW-1:0]    slot;
  logic [LW-1:0]    slot_inc;
  logic [SW-1:0]    oldest_next;
  logic [LW-1:0]    fill_next;
  logic [AW-1:0]    hist_addr;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] drop_val;
  logic [LW:0]      div_sh;
  logic             clear_now;

  assign ci_new     = cmd.chan_idx[CW-1:0];
  assign wl_wide    = 11'(window_length);
  assign fill_cur   = fill_cnt[ci_new];
  assign oldest_cur = oldest[ci_new];
  assign clear_now  = cmd_pop && (cmd.op == OP_CLEAR);

  always_comb begin
    if (window_length == '0) begin
      len_eff = LW'(1);
    end else if (wl_wide > 11'(WINDOW_MAX)) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = LW'(wl_wide);
    end
  end

  assign mod_sh      = {mod_rem, mod_x[XW-1]};
  assign slot        = mod_rem[SW-1:0];
  assign slot_inc    = LW'(slot) + LW'(1);
  assign oldest_next = (slot_inc == len_l) ? '0 : SW'(slot_inc);
  assign fill_next   = is_full ? len_l : fill_l + LW'(1);
  assign hist_addr   = {cidx, slot};
  assign drop_val    = is_full ? {{(SUM_W-DATA_W){hist_rd[DATA_W-1]}}, hist_rd} : '0;
  assign sum_next    = sum_l + {{(SUM_W-DATA_W){smp[DATA_W-1]}}, smp} - drop_val;
  assign div_sh      = {drem, dq[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          state_next = (cmd.op == OP_CLEAR) ? ST_PUSH : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_cnt == MCW'(1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_SUM;
      ST_SUM:  state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(1)) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT:  state_next = ST_PUSH;
      ST_PUSH: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Per-channel fill counts, ring heads and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_cnt[i] <= '0;
        oldest[i]   <= '0;
        wsum[i]     <= '0;
      end
    end else begin
      if (clear_now) begin
        for (int i = 0; i < CHANNELS; i++) begin
          fill_cnt[i] <= '0;
          oldest[i]   <= '0;
          wsum[i]     <= '0;
        end
      end
      if (state == ST_READ) begin
        fill_cnt[cidx] <= fill_next;
        if (is_full) begin
          oldest[cidx] <= oldest_next;
        end
      end
      if (state == ST_SUM) begin
        wsum[cidx] <= sum_next;
      end
    end
  end

  // History memory: the old entry is read and the new sample written at once.
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      hist_rd         <= hist[hist_addr];
      hist[hist_addr] <= smp;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_pop) begin
          chan_in   <= cmd.chan_in;
          cidx      <= ci_new;
          smp       <= cmd.sample;
          len_l     <= len_eff;
          fill_l    <= fill_cur;
          sum_l     <= wsum[ci_new];
          is_full   <= (fill_cur >= len_eff);
          mod_x     <= (fill_cur >= len_eff) ? XW'(oldest_cur)
                                             : XW'(oldest_cur) + XW'(fill_cur);
          mod_rem   <= '0;
          mod_cnt   <= MCW'(XW);
          res_avg   <= '0;
          res_valid <= 1'b0;
        end
      end
      ST_MOD: begin
        // One remainder bit per cycle: slot = mod_x mod len.
        if (mod_sh >= {1'b0, len_l}) begin
          mod_rem <= LW'(mod_sh - {1'b0, len_l});
        end else begin
          mod_rem <= mod_sh[LW-1:0];
        end
        mod_x   <= {mod_x[XW-2:0], 1'b0};
        mod_cnt <= mod_cnt - MCW'(1);
      end
      ST_READ: begin
        fill_l <= fill_next;
      end
      ST_SUM: begin
        sum_l <= sum_next;
      end
      ST_PREP: begin
        neg     <= sum_l[SUM_W-1];
        dq      <= sum_l[SUM_W-1] ? (~sum_l + SUM_W'(1)) : sum_l;
        drem    <= '0;
        div_cnt <= DIV_CNT_W'(DIV_STEPS);
      end
      ST_DIV: begin
        if (div_sh >= {1'b0, fill_l}) begin
          drem <= LW'(div_sh - {1'b0, fill_l});
          dq   <= {dq[SUM_W-2:0], 1'b1};
        end else begin
          drem <= div_sh[LW-1:0];
          dq   <= {dq[SUM_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      ST_SAT: begin
        res_valid <= 1'b1;
        if (neg) begin
          res_avg <= (dq > MAG_NEG_LIMIT) ? AVG_MIN : (~dq[DATA_W-1:0] + DATA_W'(1));
        end else begin
          res_avg <= (dq > MAG_POS_LIMIT) ? AVG_MAX : dq[DATA_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res.channel_res = chan_in;
  assign res.average     = res_avg;
  assign res.valid_res   = res_valid;

  // The divisor is always a legal sample count.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (fill_l != '0 && fill_l <= len_l))
    else $error("fill count outside window");

  // The divider hands over to saturation after its last step.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == DIV_CNT_W'(1)) |=> (state == ST_SAT))
    else $error("divider did not finish");

  // A clear empties the channels; the check looks at channel 0.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && clear_now) |=> (fill_cnt[0] == '0 && wsum[0] == '0))
    else $error("clear left channel state");

  // A result is only written when the result queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule

@@ src/multichannel_moving_average_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_moving_average_unit
// A sample word passes the command queue; in the engine, the per-bit ring slot
//   reduction, history read, sum update, bit-serial 40-step divider and
//   saturation; then the result queue. A clear goes from idle straight to the
//   push. The engine finishes one word before it pops the next.
// Reset: queues, engine and all channel sums and fill counts clear;
//   window_length returns to 256; the history memory is not cleared.
// ----------------------------------------------------------------------------
//
// Sliding-window mean over up to CHANNELS independent channels in Q16.16.
//
// The front end takes input words, decides whether each is a sample or a
// clear, folds the channel code into the configured channel count and writes
// a command into a two-entry queue. The engine pops commands one at a time.
// For a sample it reduces the ring position modulo the window length, reads
// the oldest history entry while writing the new sample in its place, updates
// the running 40-bit sum and divides it by the sample count with a restoring
// divider, one quotient bit per cycle. The quotient is truncated toward zero
// and saturated to 32 bits. Results go through a second two-entry queue, so
// the engine can move on while a finished word waits to be popped.
//
// History entries are only used once the channel's fill count says they were
// written, so the memory needs no clearing pass after reset.
//
// The window_length register lives at byte address 0 of the APB port. It
// should only change while the block is idle and should be followed by a
// clear word.
module multichannel_moving_average_unit import mma_pkg::*; #(
  parameter int CHANNELS   = 16,
  parameter int WINDOW_MAX = 256
) (
  input  logic               clk,
  input  logic               rst,
  // Input word queue side.
  input  logic               push,
  output logic               full,
  input  in_word_t           item,
  // Result word queue side.
  input  logic               pop,
  output logic               empty,
  output out_word_t          result,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [WLEN_W-1:0] window_length;
  logic              cfg_write;

  logic      cmd_pop;
  logic      cmd_empty;
  cmd_t      cmd;
  logic      res_full;
  logic      res_push;
  out_word_t res;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LEN_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[WLEN_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_WINDOW_LEN) ? 32'(window_length) : '0;

  // Front end: classification and command queue.
  mma_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // Back end: history, sums and division.
  mma_engine #(
    .CHANNELS   (CHANNELS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .window_length (window_length),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res)
  );

  // Result queue: decouples the engine from the consumer.
  mma_fifo #(
    .T (out_word_t)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule

@@ bench/multichannel_moving_average_unit_test.sv @@
// ----------------------------------------------------------------------------
// multichannel_moving_average_unit_test
// Self-checking bench for the multichannel moving-average unit. Input words are
// pushed with random gaps, results are popped with random stalls, and each
// result is compared field by field against an in-bench model of the
// per-channel sliding windows. The window length register is reprogrammed
// between phases, including the register extremes and two shrinks without a
// clear.
// ----------------------------------------------------------------------------
module multichannel_moving_average_unit_test;
  import mma_pkg::*;

  localparam int CHANNELS     = 16;
  localparam int WINDOW_MAX   = 256;
  // Cycles the receiver refuses results during the long hold-off.
  localparam int HOLD_CYCLES  = 400;
  // Cycles without any accepted word before the run is declared hung. The
  // longest quiet stretch of a correct run is the hold-off plus one latency.
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int N_PHASES     = 12;
  // Phase in which the window is narrowed without a following clear.
  localparam int SHRINK_PHASE = 6;

  // Window setting and word count of each random phase. The values 511 and 0
  // sit outside the useful range and act as the largest and smallest window.
  localparam logic [WLEN_W-1:0] PHASE_WIN [N_PHASES] =
    '{9'd256, 9'd1, 9'd2, 9'd3, 9'd8, 9'd17, 9'd5, 9'd64, 9'd511, 9'd0, 9'd100, 9'd256};
  localparam int PHASE_WORDS [N_PHASES] =
    '{330, 80, 80, 80, 80, 80, 80, 100, 80, 60, 80, 110};

  // Scoreboard holding its own copy of every channel's window and the queue of
  // result words still owed by the block.
  class avg_scoreboard;
    bit [WLEN_W-1:0] win_len = WINDOW_LEN_RESET;
    bit [DATA_W-1:0] ring [CHANNELS][WINDOW_MAX];
    bit [SUM_W-1:0]  ring_sum [CHANNELS];
    int unsigned     held [CHANNELS];
    int unsigned     head [CHANNELS];
    out_word_t       owed [$];
    int              fails;

    function int pending();
      return owed.size();
    endfunction

    // Works out the result of an accepted input word and queues it.
    function void note_input(in_word_t w);
      out_word_t          want;
      int unsigned        len;
      int unsigned        c;
      int unsigned        slot;
      bit [SUM_W-1:0]     s;
      bit signed [SUM_W-1:0] s_signed;
      longint             quot;
      want.channel_res = w.channel;
      if (w.mode == MODE_CLEAR) begin
        foreach (ring_sum[i]) begin
          ring_sum[i] = '0;
          held[i] = 0;
          head[i] = 0;
        end
        want.average = '0;
        want.valid_res = 1'b0;
      end else begin
        len = (win_len == 0) ? 1 : (win_len > WINDOW_MAX) ? WINDOW_MAX : win_len;
        c = w.channel % CHANNELS;
        s = ring_sum[c];
        if (held[c] < len) begin
          slot = (head[c] + held[c]) % len;
          held[c]++;
        end else begin
          // Full window: the oldest sample leaves the sum. A fill count left
          // above a narrowed window also lands here.
          slot = head[c] % len;
          s = s - {{(SUM_W-DATA_W){ring[c][slot][DATA_W-1]}}, ring[c][slot]};
          head[c] = (slot + 1) % len;
          held[c] = len;
        end
        ring[c][slot] = w.sample;
        s = s + {{(SUM_W-DATA_W){w.sample[DATA_W-1]}}, w.sample};
        ring_sum[c] = s;
        s_signed = s;
        quot = s_signed / longint'(held[c]);
        if (quot > 64'sd2147483647) begin
          want.average = AVG_MAX;
        end else if (quot < -64'sd2147483648) begin
          want.average = AVG_MIN;
        end else begin
          want.average = quot[DATA_W-1:0];
        end
        want.valid_res = 1'b1;
      end
      owed.push_back(want);
    endfunction

    // Compares a popped result word with the oldest owed one.
    function void check_result(out_word_t r);
      out_word_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing expected: channel_res %0d average %0d",
               r.channel_res, r.average);
        fails++;
        return;
      end
      want = owed.pop_front();
      if (r.channel_res !== want.channel_res) begin
        $error("channel_res: expected %0d, got %0d", want.channel_res, r.channel_res);
        fails++;
      end
      if (r.average !== want.average) begin
        $error("average: expected %0d, got %0d", want.average, r.average);
        fails++;
      end
      if (r.valid_res !== want.valid_res) begin
        $error("valid_res: expected %0b, got %0b", want.valid_res, r.valid_res);
        fails++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  in_word_t           item = '0;
  logic               pop = 1'b0;
  logic               empty;
  out_word_t          result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  avg_scoreboard sb = new;

  // Set while both sides run without random gaps.
  bit no_idle = 1'b0;
  // Raised by the sender to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  multichannel_moving_average_unit #(
    .CHANNELS  (CHANNELS),
    .WINDOW_MAX(WINDOW_MAX)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything the block accepts is seen here, at the rising edge, before the
  // block's own registers move. The result is checked before the input is
  // noted; a word accepted on this edge cannot have its result out yet.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        sb.check_result(result);
      end
      if (push && !full) begin
        sb.note_input(item);
      end
    end
  end

  // Watchdog: any accepted word, result or register access restarts the count.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("multichannel_moving_average_unit_test NOT OK");
      $finish;
    end
  end

  // Receiver. It pops with random stalls, and once on request it refuses all
  // results for a long stretch, counted here, so that both word queues and the
  // engine fill and the block raises full against the sender.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= 32);
      end
    end
  end

  // Offers one word and returns at the falling edge after it was taken. push
  // is left high so that back-to-back words need no second assignment in one
  // time step; only a random gap or a drain lowers it.
  task automatic send_word(input in_word_t w);
    while (!no_idle && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(negedge clk);
    end
    item <= w;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [DATA_W-1:0] value);
    in_word_t w;
    w.mode = MODE_SAMPLE;
    w.channel = ch;
    w.sample = value;
    send_word(w);
  endtask

  // The sample field of a clear word carries random bits; the block ignores it.
  task automatic send_clear(input logic [CHAN_W-1:0] ch);
    in_word_t w;
    w.mode = MODE_CLEAR;
    w.channel = ch;
    w.sample = $urandom();
    send_word(w);
  endtask

  // Stops offering words and waits until every owed result has been popped.
  // Every word yields exactly one result, so the block is idle afterwards.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Reads the window length register back and compares its low bits.
  task automatic check_window(input logic [WLEN_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_WINDOW_LEN;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[WLEN_W-1:0] !== want) begin
      $error("window_length readback: expected %0d, got %0d", want, prdata[WLEN_W-1:0]);
      sb.fails++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the window length. The bits above the register carry random junk
  // that the block must drop. psel stays high into the readback.
  task automatic write_window(input logic [WLEN_W-1:0] len);
    logic [31:0] wd;
    wd = $urandom();
    wd[WLEN_W-1:0] = len;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_WINDOW_LEN;
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.win_len = len;
    @(negedge clk);
    check_window(len);
  endtask

  // Sample values lean on the extremes and on small values of both signs, so
  // that saturation-free extremes and truncation toward zero come up often.
  function automatic logic [DATA_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      return AVG_MAX;
    end else if (r < 16) begin
      return AVG_MIN;
    end else if (r < 32) begin
      return DATA_W'($urandom_range(2000)) - DATA_W'(1000);
    end
    return $urandom();
  endfunction

  initial begin
    int unsigned focus;
    int unsigned focus_pct;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_window(WINDOW_LEN_RESET);

    // Directed words at the reset window of 256. Two full-scale positives must
    // average to full scale, and mixed signs must truncate toward zero.
    send_sample(4'd0, AVG_MAX);
    send_sample(4'd0, AVG_MAX);
    send_sample(4'd15, AVG_MIN);
    send_sample(4'd15, AVG_MIN);
    send_sample(4'd15, AVG_MAX);
    send_sample(4'd5, -32'sd7);
    send_sample(4'd5, 32'sd0);
    send_clear(4'd9);

    // Smallest window: each result is just the newest sample.
    wait_drained();
    write_window(9'd1);
    send_clear(4'd3);
    send_sample(4'd3, 32'sd10);
    send_sample(4'd3, -32'sd20);

    // A window of zero behaves as a window of one.
    wait_drained();
    write_window(9'd0);
    send_clear(4'd12);
    send_sample(4'd12, -32'sd3);

    // Narrowing the window without a clear leaves the old sum in place. With
    // three full-scale samples held and the window cut to one, the next mean
    // exceeds the 32-bit range and must saturate, in both directions.
    wait_drained();
    write_window(9'd3);
    send_clear(4'd10);
    repeat (3) send_sample(4'd7, AVG_MAX);
    repeat (3) send_sample(4'd6, AVG_MIN);
    wait_drained();
    write_window(9'd1);
    send_sample(4'd7, AVG_MAX);
    send_sample(4'd6, AVG_MIN);

    // Out-of-range large setting, cleared at once since it widens the window.
    wait_drained();
    write_window(9'd511);
    send_clear(4'd1);

    // Random phases. Each phase reprograms the window and clears, except the
    // one phase that narrows the window on top of the previous phase's state.
    // Most samples go to one focus channel so that windows fill and wrap.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_window(PHASE_WIN[p]);
      if (p != SHRINK_PHASE) begin
        send_clear(CHAN_W'($urandom_range(15)));
      end
      focus = $urandom_range(CHANNELS - 1);
      focus_pct = (PHASE_WIN[p] >= 64) ? 90 : 60;
      no_idle = (p == 4);
      for (int n = 0; n < PHASE_WORDS[p]; n++) begin
        if (p == 1 && n == 20) begin
          hold_req = 1'b1;
        end
        if (p == 3 && n == 40) begin
          wait_drained();
        end
        if ($urandom_range(99) < 2) begin
          send_clear(CHAN_W'($urandom_range(15)));
        end else if ($urandom_range(99) < focus_pct) begin
          send_sample(CHAN_W'(focus), pick_sample());
        end else begin
          send_sample(CHAN_W'($urandom_range(15)), pick_sample());
        end
      end
      no_idle = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d result words never arrived", sb.pending());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("multichannel_moving_average_unit_test OK");
    end else begin
      $display("multichannel_moving_average_unit_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mma_pkg.sv
src/mma_fifo.sv
src/mma_front.sv
src/mma_engine.sv
src/multichannel_moving_average_unit.sv
bench/multichannel_moving_average_unit_test.sv
